// ----- rtl/tanc_pkg.sv -----
// Shared constants for the triangle area, unit normal and centroid block.
package tanc_pkg;

    localparam int COORD_BITS       = 20;
    localparam int NORMAL_FRAC_BITS = 15;
    localparam int QUEUE_DEPTH      = 4;

endpackage

// ----- rtl/triangle_area_normal_centroid_top.sv -----
// Top level: triangle area, unit normal and centroid, one transaction per cycle while
// neither in_stall nor out_stall holds. Pipeline: 2 front stages, the queue, 4 magnitude
//   stages, (2*COORD_BITS+3) root stages, (NORMAL_FRAC_BITS+2) divide stages and 1 output
//   stage. Throughput: one triangle per cycle when not stalled, set by the fully
//   pipelined one-bit-per-stage root and divide units.
// Reset (rst_n, async, active low) clears all valid flags and queue pointers.
module triangle_area_normal_centroid_top #(
    parameter int COORD_BITS       = tanc_pkg::COORD_BITS,
    parameter int NORMAL_FRAC_BITS = tanc_pkg::NORMAL_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [COORD_BITS-1:0]     v0_x,
    input  logic signed [COORD_BITS-1:0]     v0_y,
    input  logic signed [COORD_BITS-1:0]     v0_z,
    input  logic signed [COORD_BITS-1:0]     v1_x,
    input  logic signed [COORD_BITS-1:0]     v1_y,
    input  logic signed [COORD_BITS-1:0]     v1_z,
    input  logic signed [COORD_BITS-1:0]     v2_x,
    input  logic signed [COORD_BITS-1:0]     v2_y,
    input  logic signed [COORD_BITS-1:0]     v2_z,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2*COORD_BITS+3:0]          tri_area,
    output logic signed [NORMAL_FRAC_BITS:0] unit_nx,
    output logic signed [NORMAL_FRAC_BITS:0] unit_ny,
    output logic signed [NORMAL_FRAC_BITS:0] unit_nz,
    output logic signed [COORD_BITS-1:0]     mid_x,
    output logic signed [COORD_BITS-1:0]     mid_y,
    output logic signed [COORD_BITS-1:0]     mid_z,
    output logic                             degenerate
);

    localparam int QW = 9 * COORD_BITS + 10;

    logic          q_full;
    logic          push_valid;
    logic [QW-1:0] push_data;
    logic          q_valid;
    logic [QW-1:0] q_data;
    logic          pop;

    // front end: edges, cross product, centroid, zero-normal flag
    tanc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .vtx        ({v2_z, v2_y, v2_x, v1_z, v1_y, v1_x, v0_z, v0_y, v0_x}),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // decoupling queue: front and back stall independently
    tanc_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    // back end: |N|^2, square root, three divides, output register
    tanc_back #(
        .COORD_BITS       (COORD_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tri_area   (tri_area),
        .unit_nx    (unit_nx),
        .unit_ny    (unit_ny),
        .unit_nz    (unit_nz),
        .mid_x      (mid_x),
        .mid_y      (mid_y),
        .mid_z      (mid_z),
        .degenerate (degenerate)
    );

    // a zero normal must zero the area and the unit normal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |->
            tri_area == '0 && unit_nx == '0 && unit_ny == '0 && unit_nz == '0)
        else $error("degenerate transaction with nonzero area or normal");

    // saturation keeps the most negative code off the unit normal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unit_nx != {1'b1, {NORMAL_FRAC_BITS{1'b0}}} &&
                      unit_ny != {1'b1, {NORMAL_FRAC_BITS{1'b0}}} &&
                      unit_nz != {1'b1, {NORMAL_FRAC_BITS{1'b0}}})
        else $error("unit normal reached the most negative code");

    // the front never pushes into a full queue, and a full queue holds data
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push_valid && q_valid)
        else $error("queue full handling broken");

endmodule

// ----- rtl/tanc_front.sv -----
// Front end: edge vectors, cross product, centroid and degenerate classification.
module tanc_front #(
    parameter int COORD_BITS = tanc_pkg::COORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [9*COORD_BITS-1:0]   vtx,
    input  logic                      q_full,
    output logic                      push_valid,
    output logic [9*COORD_BITS+9:0]   push_data
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int NW = 2 * D + 1;
    localparam int UW = C + 3;
    localparam int K  = C + 5;
    localparam longint unsigned MUL3_L = (64'd1 << K) / 64'd3 + 64'd1;
    localparam logic [K-2:0]    MUL3   = MUL3_L[K-2:0];
    localparam logic [UW-1:0]   BIAS   = UW'(3) << C;

    logic                  adv;
    logic                  v1_reg;
    logic                  v2_reg;
    logic signed [D-1:0]   ea_reg [3];
    logic signed [D-1:0]   eb_reg [3];
    logic [UW-1:0]         u_reg  [3];
    logic signed [D-1:0]   ea_next [3];
    logic signed [D-1:0]   eb_next [3];
    logic [UW-1:0]         u_next  [3];
    logic signed [NW-1:0]  n_reg  [3];
    logic signed [NW-1:0]  n_next [3];
    logic [C-1:0]          mid_reg  [3];
    logic [C-1:0]          mid_next [3];
    logic signed [2*D-1:0] pr [6];
    logic [UW+K-2:0]       prod3 [3];
    logic                  deg;

    assign adv      = !q_full;
    assign in_stall = q_full;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            logic signed [C-1:0] p0;
            logic signed [C-1:0] p1;
            logic signed [C-1:0] p2;
            p0 = vtx[j*C +: C];
            p1 = vtx[(3+j)*C +: C];
            p2 = vtx[(6+j)*C +: C];
            ea_next[j] = {p1[C-1], p1} - {p0[C-1], p0};
            eb_next[j] = {p2[C-1], p2} - {p0[C-1], p0};
            // biased sum keeps the floor division by three unsigned
            u_next[j]  = {{3{p0[C-1]}}, p0} + {{3{p1[C-1]}}, p1} + {{3{p2[C-1]}}, p2}
                         + UW'(1) + BIAS;
        end
    end

    always_comb
    begin
        pr[0] = ea_reg[1] * eb_reg[2];
        pr[1] = ea_reg[2] * eb_reg[1];
        pr[2] = ea_reg[2] * eb_reg[0];
        pr[3] = ea_reg[0] * eb_reg[2];
        pr[4] = ea_reg[0] * eb_reg[1];
        pr[5] = ea_reg[1] * eb_reg[0];
        for (int j = 0; j < 3; j++)
        begin
            n_next[j]   = NW'(pr[2*j]) - NW'(pr[2*j+1]);
            prod3[j]    = u_reg[j] * MUL3;
            // bias divides to 2^C, which drops out of the low C bits
            mid_next[j] = prod3[j][K+C-1:K];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ea_reg[j]  <= ea_next[j];
                eb_reg[j]  <= eb_next[j];
                u_reg[j]   <= u_next[j];
                n_reg[j]   <= n_next[j];
                mid_reg[j] <= mid_next[j];
            end
        end
    end

    assign deg        = (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
    assign push_valid = v2_reg && adv;
    assign push_data  = {deg, mid_reg[2], mid_reg[1], mid_reg[0],
                         n_reg[2], n_reg[1], n_reg[0]};

endmodule

// ----- rtl/tanc_queue.sv -----
// Short register queue decoupling the front end from the back end.
module tanc_queue #(
    parameter int W = 190
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         q_valid,
    output logic [W-1:0] q_data
);

    localparam int DEPTH = tanc_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- rtl/tanc_back.sv -----
// Back end: squared magnitude, one-bit-per-stage square root, unit-normal division, output.
module tanc_back #(
    parameter int COORD_BITS       = tanc_pkg::COORD_BITS,
    parameter int NORMAL_FRAC_BITS = tanc_pkg::NORMAL_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  logic [9*COORD_BITS+9:0]            q_data,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2*COORD_BITS+3:0]            tri_area,
    output logic signed [NORMAL_FRAC_BITS:0]   unit_nx,
    output logic signed [NORMAL_FRAC_BITS:0]   unit_ny,
    output logic signed [NORMAL_FRAC_BITS:0]   unit_nz,
    output logic signed [COORD_BITS-1:0]       mid_x,
    output logic signed [COORD_BITS-1:0]       mid_y,
    output logic signed [COORD_BITS-1:0]       mid_z,
    output logic                               degenerate
);

    localparam int C    = COORD_BITS;
    localparam int F    = NORMAL_FRAC_BITS;
    localparam int D    = C + 1;
    localparam int NW   = 2 * D + 1;
    localparam int AW   = 2 * D;
    localparam int MW   = AW + 1;
    localparam int SW   = 2 * MW;
    localparam int RW   = MW + 2;
    localparam int H    = AW / 2;
    localparam int HH   = AW - H;
    localparam int QN   = F + 2;
    localparam int ARW  = 2 * C + 4;
    localparam logic [QN-1:0] UMAX = QN'((64'd1 << F) - 64'd1);

    typedef struct packed {
        logic [2:0]     neg;
        logic           deg;
        logic [3*C-1:0] mid;
    } side_t;

    logic adv;
    assign adv = !out_valid || !out_stall;
    assign pop = adv && q_valid;

    // input unpack
    logic signed [NW-1:0] n_in [3];
    side_t                side_in;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_in[i]        = q_data[i*NW +: NW];
            side_in.neg[i] = q_data[i*NW + NW - 1];
        end
        side_in.mid = q_data[3*NW +: 3*C];
        side_in.deg = q_data[9*C+9];
    end

    // stage A: magnitudes; B: partial squares; C: squares; D: sum
    logic          va_reg, vb_reg, vc_reg;
    side_t         sa_reg, sb_reg, sc_reg;
    logic [AW-1:0] abs_a_reg [3];
    logic [AW-1:0] abs_b_reg [3];
    logic [AW-1:0] abs_c_reg [3];
    logic [AW-1:0] abs_next  [3];
    logic [2*H-1:0]  pll_reg [3];
    logic [H+HH-1:0] phl_reg [3];
    logic [2*HH-1:0] phh_reg [3];
    logic [2*AW-1:0] sq_reg  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [NW-1:0] t;
            t = n_in[i][NW-1] ? (~n_in[i] + 1'b1) : n_in[i];
            abs_next[i] = t[AW-1:0];
        end
    end

    // root pipeline, index 0 loaded from the sum stage
    logic          sq_vld  [MW+1];
    side_t         sq_side [MW+1];
    logic [RW-1:0] sq_rem  [MW+1];
    logic [MW-1:0] sq_root [MW+1];
    logic [SW-1:0] sq_src  [MW+1];
    logic [AW-1:0] sq_abs  [MW+1][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vc_reg    <= 1'b0;
            sq_vld[0] <= 1'b0;
        end
        else if (adv)
        begin
            va_reg    <= q_valid;
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            sq_vld[0] <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg <= side_in;
            sb_reg <= sa_reg;
            sc_reg <= sb_reg;
            sq_side[0] <= sc_reg;
            sq_rem[0]  <= '0;
            sq_root[0] <= '0;
            sq_src[0]  <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                abs_a_reg[i] <= abs_next[i];
                abs_b_reg[i] <= abs_a_reg[i];
                abs_c_reg[i] <= abs_b_reg[i];
                sq_abs[0][i] <= abs_c_reg[i];
                pll_reg[i]   <= abs_a_reg[i][H-1:0] * abs_a_reg[i][H-1:0];
                phl_reg[i]   <= abs_a_reg[i][AW-1:H] * abs_a_reg[i][H-1:0];
                phh_reg[i]   <= abs_a_reg[i][AW-1:H] * abs_a_reg[i][AW-1:H];
                sq_reg[i]    <= (2*AW)'(pll_reg[i]) + ((2*AW)'(phl_reg[i]) << (H + 1))
                                + ((2*AW)'(phh_reg[i]) << (2 * H));
            end
        end
    end

    // one root bit per stage
    for (genvar k = 1; k <= MW; k++)
    begin : g_sqrt
        logic [RW+1:0] cand;
        logic [RW+1:0] trial;
        logic [RW+1:0] diff;
        logic          ge;

        assign cand  = {sq_rem[k-1], sq_src[k-1][SW-1 -: 2]};
        assign trial = (RW+2)'({sq_root[k-1], 2'b01});
        assign ge    = (cand >= trial);
        assign diff  = cand - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld[k] <= 1'b0;
            else if (adv)
                sq_vld[k] <= sq_vld[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem[k]  <= ge ? diff[RW-1:0] : cand[RW-1:0];
                sq_root[k] <= {sq_root[k-1][MW-2:0], ge};
                sq_src[k]  <= sq_src[k-1] << 2;
                sq_side[k] <= sq_side[k-1];
                for (int i = 0; i < 3; i++)
                    sq_abs[k][i] <= sq_abs[k-1][i];
            end
        end
    end

    // one quotient bit per stage, three lanes
    logic          dv_vld  [QN];
    side_t         dv_side [QN];
    logic [MW-1:0] dv_m    [QN];
    logic [MW-1:0] dv_rem  [QN][3];
    logic [QN-1:0] dv_q    [QN][3];

    for (genvar j = 0; j < QN; j++)
    begin : g_div
        logic [MW:0]   r2  [3];
        logic          ge  [3];
        logic [MW:0]   dif [3];
        logic [MW-1:0] den;
        logic          vin;
        side_t         sin;

        if (j == 0)
        begin : g_first
            assign den = sq_root[MW];
            assign vin = sq_vld[MW];
            assign sin = sq_side[MW];
            for (genvar i = 0; i < 3; i++)
            begin : g_ln
                assign r2[i]  = (MW+1)'(sq_abs[MW][i]);
                assign ge[i]  = (r2[i] >= {1'b0, den});
                assign dif[i] = r2[i] - {1'b0, den};
            end
        end
        else
        begin : g_iter
            assign den = dv_m[j-1];
            assign vin = dv_vld[j-1];
            assign sin = dv_side[j-1];
            for (genvar i = 0; i < 3; i++)
            begin : g_ln
                assign r2[i]  = {dv_rem[j-1][i], 1'b0};
                assign ge[i]  = (r2[i] >= {1'b0, den});
                assign dif[i] = r2[i] - {1'b0, den};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld[j] <= 1'b0;
            else if (adv)
                dv_vld[j] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_m[j]    <= den;
                dv_side[j] <= sin;
                for (int i = 0; i < 3; i++)
                begin
                    dv_rem[j][i] <= ge[i] ? dif[i][MW-1:0] : r2[i][MW-1:0];
                    if (j == 0)
                        dv_q[j][i] <= QN'(ge[i]);
                    else
                        dv_q[j][i] <= {dv_q[(j == 0) ? 0 : j-1][i][QN-2:0], ge[i]};
                end
            end
        end
    end

    // output register: rounding, saturation, sign, area
    logic signed [F:0] un_next [3];
    logic [ARW-1:0]    area_next;
    logic [MW:0]       mp1;
    side_t             sf;

    assign sf  = dv_side[QN-1];
    assign mp1 = {1'b0, dv_m[QN-1]} + 1'b1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [QN:0]   qp1;
            logic [QN-1:0] qr;
            logic [F-1:0]  u;
            logic [F:0]    mag;
            qp1 = {1'b0, dv_q[QN-1][i]} + 1'b1;
            qr  = qp1[QN:1];
            u   = (qr > UMAX) ? UMAX[F-1:0] : qr[F-1:0];
            mag = {1'b0, u};
            if (sf.deg)
                un_next[i] = '0;
            else
                un_next[i] = sf.neg[i] ? -mag : mag;
        end
        area_next = sf.deg ? '0 : ARW'(mp1[MW:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= dv_vld[QN-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tri_area   <= area_next;
            unit_nx    <= un_next[0];
            unit_ny    <= un_next[1];
            unit_nz    <= un_next[2];
            mid_x      <= sf.mid[0 +: C];
            mid_y      <= sf.mid[C +: C];
            mid_z      <= sf.mid[2*C +: C];
            degenerate <= sf.deg;
        end
    end

endmodule
